FILE: rtl/bbc_pkg.sv
package bbc_pkg;

  localparam int NUM_SLOTS = 32;
  localparam int IDX_W     = $clog2(NUM_SLOTS);
  localparam int SLOT_W    = 5;
  localparam int DEV_W     = 8;
  localparam int BLK_W     = 32;
  localparam int CNT_W     = 8;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  typedef logic [IDX_W-1:0] idx_t;

  typedef enum logic [1:0] {
    OP_GET     = 2'd0,
    OP_RELEASE = 2'd1,
    OP_PIN     = 2'd2,
    OP_UNPIN   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_NOFREE = 2'd1,
    STAT_UNDER  = 2'd2,
    STAT_SAT    = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_HIT_SCAN,
    SEQ_FREE_SCAN,
    SEQ_COMMIT
  } seq_state_t;

endpackage

FILE: rtl/block_buffer_cache_lru.sv
// LRU buffer cache slot manager with reference counts.
// Input channel (in_valid/in_ready) carries one request: op, device,
// block_number and slot_in. Output channel (out_valid/out_ready) returns one
// result per request: slot_out, status, hit, need_fill, ref_count.
// A get walks the slot table one entry a cycle through a single compare unit:
// a pass over all slots looking for a tag match, and on a miss a second pass
// for the least recent free slot, then the commit state. Release, pin and
// unpin skip both passes and go straight to commit. in_ready is high only
// while the sequencer is idle; one request is worked on at a time.
// The result sits in an output register, so a new request is taken while the
// previous result waits; if the receiver stalls, the commit cycle of the next
// request waits until the output register is free.
// Synchronous reset clears all tags, valid bits and counts to zero and sets
// the recency order so that the last slot is the most recent.
module block_buffer_cache_lru
  import bbc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        op,
  input  logic [DEV_W-1:0]  device,
  input  logic [BLK_W-1:0]  block_number,
  input  logic [SLOT_W-1:0] slot_in,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [SLOT_W-1:0] slot_out,
  output logic [1:0]        status,
  output logic              hit,
  output logic              need_fill,
  output logic [CNT_W-1:0]  ref_count
);

  logic [DEV_W-1:0] tag_device      [NUM_SLOTS];
  logic [BLK_W-1:0] tag_block       [NUM_SLOTS];
  logic             data_valid      [NUM_SLOTS];
  logic [CNT_W-1:0] reference_count [NUM_SLOTS];
  idx_t             recency_rank    [NUM_SLOTS];

  seq_state_t state, state_next;
  idx_t idx, idx_next;
  idx_t sel, sel_next;
  idx_t best, best_next;
  logic found, found_next;
  logic hit_mode, hit_mode_next;

  op_t              op_q;
  logic [DEV_W-1:0] dev_q;
  logic [BLK_W-1:0] blk_q;
  logic [SLOT_W-1:0] slot_q;

  idx_t             rd;
  logic [DEV_W-1:0] r_dev;
  logic [BLK_W-1:0] r_blk;
  logic             r_valid;
  logic [CNT_W-1:0] r_cnt;
  idx_t             r_rank;
  logic             match, last, range_ok, cand;

  logic             load_out, tag_we, cnt_we, valid_we, promote;
  logic [CNT_W-1:0] cnt_wdata;
  logic [SLOT_W-1:0] o_slot;
  status_t          o_status;
  logic             o_hit, o_fill;
  logic [CNT_W-1:0] o_cnt;
  logic [NUM_SLOTS-1:0] rank_zero;

  // single read port of the slot table
  assign rd       = (state == SEQ_COMMIT) ? sel : idx;
  assign r_dev    = tag_device[rd];
  assign r_blk    = tag_block[rd];
  assign r_valid  = data_valid[rd];
  assign r_cnt    = reference_count[rd];
  assign r_rank   = recency_rank[rd];
  assign match    = (r_dev == dev_q) && (r_blk == blk_q);
  assign last     = (idx == idx_t'(NUM_SLOTS - 1));
  assign range_ok = (int'(slot_q) < NUM_SLOTS);

  always_comb begin
    state_next    = state;
    idx_next      = idx;
    sel_next      = sel;
    best_next     = best;
    found_next    = found;
    hit_mode_next = hit_mode;
    in_ready      = 1'b0;
    load_out      = 1'b0;
    tag_we        = 1'b0;
    cnt_we        = 1'b0;
    valid_we      = 1'b0;
    promote       = 1'b0;
    cnt_wdata     = r_cnt;
    cand          = 1'b0;
    o_slot        = SLOT_W'(sel);
    o_status      = STAT_OK;
    o_hit         = 1'b0;
    o_fill        = 1'b0;
    o_cnt         = '0;
    unique case (state)
      SEQ_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          idx_next      = '0;
          found_next    = 1'b0;
          hit_mode_next = 1'b0;
          if (op_t'(op) == OP_GET) begin
            state_next = SEQ_HIT_SCAN;
          end else begin
            sel_next   = idx_t'(slot_in);
            state_next = SEQ_COMMIT;
          end
        end
      end
      SEQ_HIT_SCAN: begin
        // most recent matching tag, valid or not
        cand = match && (!found || (r_rank < best));
        if (cand) begin
          found_next = 1'b1;
          best_next  = r_rank;
          sel_next   = idx;
        end
        if (last) begin
          if (found || cand) begin
            hit_mode_next = 1'b1;
            state_next    = SEQ_COMMIT;
          end else begin
            found_next = 1'b0;
            idx_next   = '0;
            state_next = SEQ_FREE_SCAN;
          end
        end else begin
          idx_next = idx + idx_t'(1);
        end
      end
      SEQ_FREE_SCAN: begin
        // least recent slot with no references
        cand = (r_cnt == '0) && (!found || (r_rank > best));
        if (cand) begin
          found_next = 1'b1;
          best_next  = r_rank;
          sel_next   = idx;
        end
        if (last) begin
          state_next = SEQ_COMMIT;
        end else begin
          idx_next = idx + idx_t'(1);
        end
      end
      SEQ_COMMIT: begin
        if (!out_valid || out_ready) begin
          load_out   = 1'b1;
          state_next = SEQ_IDLE;
          if (op_q == OP_GET) begin
            if (hit_mode) begin
              o_hit = 1'b1;
              if (r_cnt == CNT_MAX) begin
                o_status = STAT_SAT;
                o_cnt    = CNT_MAX;
              end else begin
                cnt_we    = 1'b1;
                valid_we  = 1'b1;
                cnt_wdata = r_cnt + CNT_W'(1);
                o_fill    = !r_valid;
                o_cnt     = cnt_wdata;
              end
            end else if (found) begin
              tag_we    = 1'b1;
              cnt_we    = 1'b1;
              valid_we  = 1'b1;
              cnt_wdata = CNT_W'(1);
              o_fill    = 1'b1;
              o_cnt     = cnt_wdata;
            end else begin
              o_slot   = '0;
              o_status = STAT_NOFREE;
            end
          end else if (!range_ok) begin
            o_slot   = slot_q;
            o_status = STAT_NOFREE;
          end else if (op_q == OP_PIN) begin
            if (r_cnt == CNT_MAX) begin
              o_status = STAT_SAT;
              o_cnt    = CNT_MAX;
            end else begin
              cnt_we    = 1'b1;
              cnt_wdata = r_cnt + CNT_W'(1);
              o_cnt     = cnt_wdata;
            end
          end else begin
            if (r_cnt == '0) begin
              o_status = STAT_UNDER;
            end else begin
              cnt_we    = 1'b1;
              cnt_wdata = r_cnt - CNT_W'(1);
              o_cnt     = cnt_wdata;
              promote   = (op_q == OP_RELEASE) && (cnt_wdata == '0);
            end
          end
        end
      end
      default: state_next = SEQ_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SEQ_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      sel       <= '0;
      best      <= '0;
      found     <= 1'b0;
      hit_mode  <= 1'b0;
      out_valid <= 1'b0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        tag_device[i]      <= '0;
        tag_block[i]       <= '0;
        data_valid[i]      <= 1'b0;
        reference_count[i] <= '0;
        recency_rank[i]    <= idx_t'(NUM_SLOTS - 1 - i);
      end
    end else begin
      idx      <= idx_next;
      sel      <= sel_next;
      best     <= best_next;
      found    <= found_next;
      hit_mode <= hit_mode_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (tag_we) begin
        tag_device[sel] <= dev_q;
        tag_block[sel]  <= blk_q;
      end
      if (valid_we) begin
        data_valid[sel] <= 1'b1;
      end
      if (cnt_we) begin
        reference_count[sel] <= cnt_wdata;
      end
      if (promote) begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (recency_rank[i] < recency_rank[sel]) begin
            recency_rank[i] <= recency_rank[i] + idx_t'(1);
          end
        end
        recency_rank[sel] <= '0;
      end
    end
  end

  // request and result payload
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_q   <= op_t'(op);
      dev_q  <= device;
      blk_q  <= block_number;
      slot_q <= slot_in;
    end
    if (load_out) begin
      slot_out  <= o_slot;
      status    <= o_status;
      hit       <= o_hit;
      need_fill <= o_fill;
      ref_count <= o_cnt;
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      rank_zero[i] = (recency_rank[i] == '0);
    end
  end

  a_one_most_recent: assert property (@(posedge clk) disable iff (rst)
    $onehot(rank_zero))
    else $error("recency order lost its most recent slot");

  a_nofree_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == STAT_NOFREE) |-> !hit && !need_fill && (ref_count == '0))
    else $error("no-free result carries data");

  a_ok_get_counted: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == STAT_OK) && (hit || need_fill) |-> (ref_count != '0))
    else $error("granted slot has zero references");

  a_busy_not_ready: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while sequencer busy");

endmodule

FILE: dv/block_buffer_cache_lru_tb.sv
`timescale 1ns / 1ps

module block_buffer_cache_lru_tb
  import bbc_pkg::*;
();

  localparam int TOTAL_ITEMS    = 650;
  localparam int CALM_ITEMS     = 60;
  localparam int LONG_HOLD      = 300;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int TAG_POOL       = 40;

  typedef struct {
    logic [SLOT_W-1:0] slot;
    status_t           status;
    logic              hit;
    logic              fill;
    logic [CNT_W-1:0]  count;
  } slot_result_t;

  class cache_scoreboard;
    logic [DEV_W-1:0] tag_dev [NUM_SLOTS];
    logic [BLK_W-1:0] tag_blk [NUM_SLOTS];
    logic             data_ok [NUM_SLOTS];
    logic [CNT_W-1:0] ref_cnt [NUM_SLOTS];
    int               rank    [NUM_SLOTS];
    slot_result_t     results_due[$];
    int               failures;

    function new();
      for (int i = 0; i < NUM_SLOTS; i++) begin
        tag_dev[i] = '0;
        tag_blk[i] = '0;
        data_ok[i] = 1'b0;
        ref_cnt[i] = '0;
        rank[i]    = NUM_SLOTS - 1 - i;
      end
      failures = 0;
    endfunction

    function int pending();
      return results_due.size();
    endfunction

    function void bump_to_front(int s);
      int r0;
      r0 = rank[s];
      for (int i = 0; i < NUM_SLOTS; i++)
        if (rank[i] < r0) rank[i]++;
      rank[s] = 0;
    endfunction

    // predicts the result of one accepted request and queues it
    function slot_result_t note_request(op_t req_op, logic [DEV_W-1:0] dev,
                                        logic [BLK_W-1:0] blk, logic [SLOT_W-1:0] sidx);
      slot_result_t r;
      int           found;
      int           victim;
      int           s;
      r.slot   = '0;
      r.status = STAT_OK;
      r.hit    = 1'b0;
      r.fill   = 1'b0;
      r.count  = '0;
      found    = -1;
      victim   = -1;
      s        = int'(sidx);
      if (req_op == OP_GET) begin
        for (int i = 0; i < NUM_SLOTS; i++)
          if (tag_dev[i] == dev && tag_blk[i] == blk)
            if (found < 0 || rank[i] < rank[found]) found = i;
        if (found >= 0) begin
          r.slot = SLOT_W'(found);
          r.hit  = 1'b1;
          if (ref_cnt[found] == CNT_MAX) begin
            r.status = STAT_SAT;
            r.count  = CNT_MAX;
          end else begin
            ref_cnt[found]++;
            r.fill          = !data_ok[found];
            data_ok[found]  = 1'b1;
            r.count         = ref_cnt[found];
          end
        end else begin
          for (int i = 0; i < NUM_SLOTS; i++)
            if (ref_cnt[i] == '0)
              if (victim < 0 || rank[i] > rank[victim]) victim = i;
          if (victim < 0) begin
            r.status = STAT_NOFREE;
          end else begin
            tag_dev[victim] = dev;
            tag_blk[victim] = blk;
            ref_cnt[victim] = CNT_W'(1);
            data_ok[victim] = 1'b1;
            r.slot  = SLOT_W'(victim);
            r.fill  = 1'b1;
            r.count = CNT_W'(1);
          end
        end
      end else if (s >= NUM_SLOTS) begin
        r.slot   = sidx;
        r.status = STAT_NOFREE;
      end else if (req_op == OP_PIN) begin
        r.slot = sidx;
        if (ref_cnt[s] == CNT_MAX) begin
          r.status = STAT_SAT;
          r.count  = CNT_MAX;
        end else begin
          ref_cnt[s]++;
          r.count = ref_cnt[s];
        end
      end else begin
        r.slot = sidx;
        if (ref_cnt[s] == '0) begin
          r.status = STAT_UNDER;
        end else begin
          ref_cnt[s]--;
          if (req_op == OP_RELEASE && ref_cnt[s] == '0) bump_to_front(s);
          r.count = ref_cnt[s];
        end
      end
      results_due.push_back(r);
      return r;
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        failures++;
      end
    endfunction

    function void check_result(logic [SLOT_W-1:0] slot, logic [1:0] stat, logic hit_bit,
                               logic fill_bit, logic [CNT_W-1:0] cnt);
      slot_result_t w;
      if (results_due.size() == 0) begin
        $error("result with no request outstanding: slot_out %0d status %0d", slot, stat);
        failures++;
        return;
      end
      w = results_due.pop_front();
      compare_field("slot_out", 32'(w.slot), 32'(slot));
      compare_field("status", 32'(w.status), 32'(stat));
      compare_field("hit", 32'(w.hit), 32'(hit_bit));
      compare_field("need_fill", 32'(w.fill), 32'(fill_bit));
      compare_field("ref_count", 32'(w.count), 32'(cnt));
    endfunction
  endclass

  logic              clk;
  logic              rst;
  logic              in_valid;
  logic              in_ready;
  logic [1:0]        op;
  logic [DEV_W-1:0]  device;
  logic [BLK_W-1:0]  block_number;
  logic [SLOT_W-1:0] slot_in;
  logic              out_valid;
  logic              out_ready;
  logic [SLOT_W-1:0] slot_out;
  logic [1:0]        status;
  logic              hit;
  logic              need_fill;
  logic [CNT_W-1:0]  ref_count;

  cache_scoreboard cache_sb = new();
  bit              calm;
  bit              long_hold_req;
  int              items_sent;
  int              held_slots[$];
  logic [DEV_W-1:0] pool_dev [TAG_POOL];
  logic [BLK_W-1:0] pool_blk [TAG_POOL];

  block_buffer_cache_lru i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .op           (op),
    .device       (device),
    .block_number (block_number),
    .slot_in      (slot_in),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .slot_out     (slot_out),
    .status       (status),
    .hit          (hit),
    .need_fill    (need_fill),
    .ref_count    (ref_count)
  );

  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  task automatic send_request(input op_t req_op, input logic [DEV_W-1:0] dev,
                              input logic [BLK_W-1:0] blk, input logic [SLOT_W-1:0] sidx,
                              output slot_result_t res);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    op           <= req_op;
    device       <= dev;
    block_number <= blk;
    slot_in      <= sidx;
    do @(posedge clk); while (!in_ready);
    res = cache_sb.note_request(req_op, dev, blk, sidx);
    items_sent++;
  endtask

  task automatic get_block(input logic [DEV_W-1:0] dev, input logic [BLK_W-1:0] blk,
                           output slot_result_t res);
    send_request(OP_GET, dev, blk, SLOT_W'($urandom), res);
    if (res.status == STAT_OK) held_slots.push_back(int'(res.slot));
  endtask

  task automatic slot_request(input op_t req_op, input int s, output slot_result_t res);
    send_request(req_op, DEV_W'($urandom), BLK_W'($urandom), SLOT_W'(s), res);
  endtask

  task automatic pause_until_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (cache_sb.pending() != 0);
  endtask

  // pin every free slot, then a miss finds no victim
  task automatic fill_all_slots();
    slot_result_t r;
    int           pinned[$];
    for (int s = 0; s < NUM_SLOTS; s++)
      if (cache_sb.ref_cnt[s] == '0) begin
        slot_request(OP_PIN, s, r);
        pinned.push_back(s);
      end
    get_block(DEV_W'($urandom), BLK_W'($urandom), r);
    get_block(pool_dev[$urandom_range(0, TAG_POOL-1)],
              pool_blk[$urandom_range(0, TAG_POOL-1)], r);
    foreach (pinned[k])
      slot_request(($urandom_range(0, 1) == 0) ? OP_UNPIN : OP_RELEASE, pinned[k], r);
  endtask

  // drive one slot's count to the ceiling, then overflow it by pin and by get
  task automatic saturate_slot();
    slot_result_t r;
    int           k;
    int           s;
    k = $urandom_range(2, TAG_POOL-1);
    get_block(pool_dev[k], pool_blk[k], r);
    if (r.status == STAT_OK) begin
      s = int'(r.slot);
      while (cache_sb.ref_cnt[s] != CNT_MAX) slot_request(OP_PIN, s, r);
      slot_request(OP_PIN, s, r);
      get_block(pool_dev[k], pool_blk[k], r);
    end
  endtask

  task automatic random_request();
    slot_result_t r;
    int           pick;
    int           k;
    int           j;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      if ($urandom_range(0, 9) == 0) begin
        get_block(DEV_W'($urandom), BLK_W'($urandom), r);
      end else begin
        k = $urandom_range(0, TAG_POOL-1);
        get_block(pool_dev[k], pool_blk[k], r);
      end
    end else if (pick < 75 && held_slots.size() != 0) begin
      j = $urandom_range(0, held_slots.size()-1);
      slot_request(OP_RELEASE, held_slots[j], r);
      held_slots.delete(j);
    end else if (pick < 92) begin
      slot_request(op_t'($urandom_range(1, 3)), $urandom_range(0, 31), r);
    end else if (pick < 99) begin
      if (held_slots.size() != 0) begin
        j = held_slots[$urandom_range(0, held_slots.size()-1)];
        slot_request(OP_PIN, j, r);
        held_slots.push_back(j);
      end else begin
        slot_request(OP_PIN, $urandom_range(0, 31), r);
      end
    end else begin
      fill_all_slots();
    end
  endtask

  initial begin
    slot_result_t r;
    bit           did_full;
    bit           did_sat;
    bit           did_hold;
    bit           did_drain;
    rst          <= 1'b1;
    in_valid     <= 1'b0;
    op           <= OP_GET;
    device       <= '0;
    block_number <= '0;
    slot_in      <= '0;
    calm          = 1'b0;
    long_hold_req = 1'b0;
    items_sent    = 0;
    did_full      = 1'b0;
    did_sat       = 1'b0;
    did_hold      = 1'b0;
    did_drain     = 1'b0;
    pool_dev[0] = '0;
    pool_blk[0] = '0;
    pool_dev[1] = '1;
    pool_blk[1] = '1;
    for (int k = 2; k < TAG_POOL; k++) begin
      pool_dev[k] = DEV_W'($urandom_range(0, 3));
      pool_blk[k] = BLK_W'($urandom);
    end
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // reset tags match device 0 block 0
    get_block('0, '0, r);
    get_block('0, '0, r);
    get_block('1, '1, r);
    get_block('1, '1, r);
    slot_request(OP_RELEASE, 0, r);
    slot_request(OP_RELEASE, 0, r);
    slot_request(OP_RELEASE, 0, r);
    slot_request(OP_UNPIN, 5, r);
    slot_request(OP_PIN, 31, r);
    slot_request(OP_UNPIN, 31, r);
    slot_request(OP_RELEASE, 31, r);
    slot_request(OP_RELEASE, 31, r);
    slot_request(OP_UNPIN, 31, r);
    get_block(8'h5A, 32'hA5A5_A5A5, r);
    get_block(8'hA5, 32'h5A5A_5A5A, r);
    slot_request(OP_PIN, 30, r);
    slot_request(OP_RELEASE, 30, r);
    slot_request(OP_PIN, 2, r);
    slot_request(OP_UNPIN, 2, r);
    held_slots.delete();

    while (items_sent < TOTAL_ITEMS) begin
      if (items_sent >= TOTAL_ITEMS - CALM_ITEMS) calm = 1'b1;
      if (!did_full && items_sent > 80) begin
        did_full = 1'b1;
        fill_all_slots();
      end else if (!did_sat && items_sent > 150) begin
        did_sat = 1'b1;
        saturate_slot();
      end else if (!did_hold && items_sent > 200) begin
        did_hold      = 1'b1;
        long_hold_req = 1'b1;
        random_request();
      end else if (!did_drain && items_sent > 480) begin
        did_drain = 1'b1;
        pause_until_drained();
      end else begin
        random_request();
      end
    end

    in_valid <= 1'b0;
    do @(posedge clk); while (cache_sb.pending() != 0);
    repeat (2 * NUM_SLOTS + 8) @(posedge clk);
    if (cache_sb.failures == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // result side: random stalls, one long hold-off on request
  initial begin
    int ready_hold;
    ready_hold = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        ready_hold    = LONG_HOLD;
      end
      if (ready_hold > 0) begin
        ready_hold--;
        out_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        ready_hold = $urandom_range(0, 12);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      cache_sb.check_result(slot_out, status, hit, need_fill, ref_count);
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

FILE: files.f
rtl/bbc_pkg.sv
rtl/block_buffer_cache_lru.sv
dv/block_buffer_cache_lru_tb.sv
